@@ hdl/button_gesture_decoder_defines.svh @@
// Assertion macros for the button gesture decoder.
// Included by the port checker; no other dependencies.
`ifndef BUTTON_GESTURE_DECODER_DEFINES_SVH
`define BUTTON_GESTURE_DECODER_DEFINES_SVH

// same-cycle implication under reset
`define BGD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgd assertion failed");

// next-cycle implication under reset
`define BGD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgd assertion failed");

`endif

@@ hdl/bgd_pkg.sv @@
// Shared types, codes and helpers for the button gesture decoder.
// No dependencies.
`default_nettype none

package bgd_pkg;

  localparam int TIME_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAX_EV          = 7;
  localparam int CNT_W           = $clog2(MAX_EV + 1);
  localparam int CFG_W           = 16;

  localparam logic [1:0] BTN_A = 2'd0;
  localparam logic [1:0] BTN_B = 2'd1;
  localparam logic [1:0] BTN_C = 2'd2;
  localparam logic [1:0] BTN_D = 2'd3;

  typedef enum logic [3:0] {
    EV_PLAYPAUSE  = 4'd0,
    EV_PREV       = 4'd1,
    EV_NEXT       = 4'd2,
    EV_VOLDOWN    = 4'd3,
    EV_VOLUP      = 4'd4,
    EV_SLEEP      = 4'd5,
    EV_HEADPHONES = 4'd6,
    EV_MODETOGGLE = 4'd7,
    EV_SLEEPWARN  = 4'd8,
    EV_BATTERY    = 4'd9,
    EV_SYNC       = 4'd10
  } event_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DCLICK   = 2'd1,
    REG_SLEEP    = 2'd2,
    REG_LONG     = 2'd3
  } reg_idx_e;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [1:0]  btn_sel;
    logic        pressed;
    logic [31:0] timestamp;
    logic [3:0]  pins_low;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [1:0]       idx;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  // all events one item causes, in emission order
  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    event_e [MAX_EV-1:0]      codes;
  } bundle_t;

  function automatic bundle_t push_ev(bundle_t b, event_e c);
    bundle_t r;
    r = b;
    if (b.cnt < CNT_W'(MAX_EV)) begin
      r.codes[b.cnt] = c;
      r.cnt          = b.cnt + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bgd_front.sv @@
// Front end: config registers, per-button gesture state and event classification.
// Depends on bgd_pkg.
`default_nettype none

module bgd_front import bgd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_wr_t  cfg_i,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  output bundle_t       bundle_o
);

  typedef logic [TIME_BITS-1:0] tm_t;

  logic [CFG_W-1:0] deb_q, dcw_q, slp_q, lng_q;
  tm_t deb_t, dcw_t, slp_t, lng_t;

  logic [3:0] held_q, held_d, long_q, long_d, warn_q, warn_d;
  tm_t        press_q [4], press_d [4];
  tm_t        edge_q  [4], edge_d  [4];
  tm_t        rel_q   [2], rel_d   [2];
  logic [1:0] tally_q [2], tally_d [2];
  logic       cmb_act_q, cmb_act_d, cmb_fired_q, cmb_fired_d;
  tm_t        cmb_start_q, cmb_start_d;

  tm_t        now;
  tm_t        hold_time [4];
  tm_t        since_edge, since_combo;
  tm_t        since_rel [2];
  logic [1:0] id, other;
  bundle_t    bun;

  assign deb_t = TIME_BITS'(deb_q);
  assign dcw_t = TIME_BITS'(dcw_q);
  assign slp_t = TIME_BITS'(slp_q);
  assign lng_t = TIME_BITS'(lng_q);

  assign now   = item_i.timestamp[TIME_BITS-1:0];
  assign id    = item_i.btn_sel;
  assign other = {1'b0, ~id[0]};

  // wrapping differences, all in parallel
  always_comb begin
    for (int i = 0; i < 4; i++) hold_time[i] = now - press_q[i];
    for (int i = 0; i < 2; i++) since_rel[i] = now - rel_q[i];
    since_edge  = now - edge_q[id];
    since_combo = now - cmb_start_q;
  end

  always_comb begin
    held_d      = held_q;
    long_d      = long_q;
    warn_d      = warn_q;
    press_d     = press_q;
    edge_d      = edge_q;
    rel_d       = rel_q;
    tally_d     = tally_q;
    cmb_act_d   = cmb_act_q;
    cmb_fired_d = cmb_fired_q;
    cmb_start_d = cmb_start_q;
    bun         = '0;

    if (accept_i && item_i.kind == KIND_EDGE) begin
      if (since_edge >= deb_t) begin
        edge_d[id] = now;
        if (item_i.pressed) begin
          if (!held_q[id]) begin
            held_d[id]  = 1'b1;
            press_d[id] = now;
            long_d[id]  = 1'b0;
            warn_d[id]  = 1'b0;
            if (!id[1] && held_q[other] && !cmb_act_q && !cmb_fired_q) begin
              cmb_act_d   = 1'b1;
              cmb_start_d = now;
              cmb_fired_d = 1'b0;
            end
          end
        end else if (held_q[id]) begin
          held_d[id] = 1'b0;
          if (!id[1]) begin
            cmb_act_d   = 1'b0;
            cmb_start_d = '0;
            cmb_fired_d = 1'b0;
          end
          if (long_q[id]) begin
            long_d[id] = 1'b0;
          end else if (hold_time[id] >= slp_t) begin
            if (id == BTN_D) bun = push_ev(bun, EV_SLEEP);
          end else if (!id[1]) begin
            tally_d[id[0]] = (tally_q[id[0]] == 2'd2) ? 2'd2 : tally_q[id[0]] + 2'd1;
            rel_d[id[0]]   = now;
          end else if (id == BTN_C) begin
            bun = push_ev(bun, EV_VOLDOWN);
          end else begin
            bun = push_ev(bun, EV_VOLUP);
          end
        end
      end
    end else if (accept_i) begin
      // pending clicks resolve after a quiet window
      for (int i = 0; i < 2; i++) begin
        if (tally_d[i] != 2'd0 && !held_d[i] && since_rel[i] >= dcw_t) begin
          if (tally_d[i] == 2'd2) bun = push_ev(bun, (i == 0) ? EV_PREV : EV_NEXT);
          else bun = push_ev(bun, EV_PLAYPAUSE);
          tally_d[i] = 2'd0;
        end
      end
      for (int i = 0; i < 4; i++) begin
        if (held_d[i] && !long_d[i]) begin
          if (!item_i.pins_low[i]) begin
            // release edge was lost: act on it at tick time
            held_d[i] = 1'b0;
            if (hold_time[i] < slp_t) begin
              if (i == 2) bun = push_ev(bun, EV_VOLDOWN);
              else if (i == 3) bun = push_ev(bun, EV_VOLUP);
              else begin
                tally_d[i[0]] = (tally_d[i[0]] == 2'd2) ? 2'd2 : tally_d[i[0]] + 2'd1;
                rel_d[i[0]]   = now;
              end
            end else if (warn_d[i] && i == 3) begin
              bun = push_ev(bun, EV_SLEEP);
            end
            long_d[i] = 1'b0;
            warn_d[i] = 1'b0;
          end else begin
            if (i == 0 && hold_time[i] >= lng_t && !held_d[1]) begin
              long_d[0]  = 1'b1;
              tally_d[0] = 2'd0;
              bun = push_ev(bun, EV_HEADPHONES);
            end
            if (i == 1 && hold_time[i] >= slp_t && !held_d[0]) begin
              long_d[1]  = 1'b1;
              tally_d[1] = 2'd0;
              bun = push_ev(bun, EV_MODETOGGLE);
            end
            if (i == 3 && hold_time[i] >= slp_t && !warn_d[3] && !long_d[3]) begin
              warn_d[3] = 1'b1;
              bun = push_ev(bun, EV_SLEEPWARN);
            end
            if (i == 2 && hold_time[i] >= lng_t && !long_d[2]) begin
              long_d[2] = 1'b1;
              bun = push_ev(bun, EV_BATTERY);
            end
          end
        end
      end
      if (cmb_act_d && !cmb_fired_d && held_d[0] && held_d[1] && since_combo >= lng_t) begin
        cmb_fired_d = 1'b1;
        long_d[0]   = 1'b1;
        long_d[1]   = 1'b1;
        tally_d[0]  = 2'd0;
        tally_d[1]  = 2'd0;
        bun = push_ev(bun, EV_SYNC);
      end
    end
  end

  assign bundle_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= CFG_W'(50);
      dcw_q <= CFG_W'(350);
      slp_q <= CFG_W'(1000);
      lng_q <= CFG_W'(2000);
    end else if (cfg_i.we) begin
      case (reg_idx_e'(cfg_i.idx))
        REG_DEBOUNCE: deb_q <= cfg_i.data;
        REG_DCLICK:   dcw_q <= cfg_i.data;
        REG_SLEEP:    slp_q <= cfg_i.data;
        REG_LONG:     lng_q <= cfg_i.data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      long_q      <= '0;
      warn_q      <= '0;
      press_q     <= '{default: '0};
      edge_q      <= '{default: '0};
      rel_q       <= '{default: '0};
      tally_q     <= '{default: '0};
      cmb_act_q   <= 1'b0;
      cmb_fired_q <= 1'b0;
      cmb_start_q <= '0;
    end else begin
      held_q      <= held_d;
      long_q      <= long_d;
      warn_q      <= warn_d;
      press_q     <= press_d;
      edge_q      <= edge_d;
      rel_q       <= rel_d;
      tally_q     <= tally_d;
      cmb_act_q   <= cmb_act_d;
      cmb_fired_q <= cmb_fired_d;
      cmb_start_q <= cmb_start_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bgd_fifo.sv @@
// Short queue of event bundles between the front end and the serializer.
// Depends on bgd_pkg.
`default_nettype none

module bgd_fifo import bgd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t data_i,
  input  wire logic    pop_i,
  output logic         full_o,
  output logic         empty_o,
  output bundle_t      head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  bundle_t             mem_q [DEPTH];
  logic [PTR_W-1:0]    wr_q, rd_q;
  logic [CNT_QW-1:0]   cnt_q;
  logic                do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CNT_QW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ptr_inc(wr_q);
      if (do_pop)  rd_q <= ptr_inc(rd_q);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_QW'(1);
        2'b01:   cnt_q <= cnt_q - CNT_QW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/bgd_back.sv @@
// Back end: walks the head bundle and hands out one event per beat.
// Depends on bgd_pkg.
`default_nettype none

module bgd_back import bgd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    empty_i,
  input  wire bundle_t head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_item_t    out_data_o
);

  logic [CNT_W-1:0] idx_q;
  logic             is_last, beat;

  assign is_last                = (idx_q == head_i.cnt - CNT_W'(1));
  assign out_valid_o            = !empty_i;
  assign out_data_o.event_code  = head_i.codes[idx_q];
  assign out_data_o.last        = is_last;
  assign beat                   = out_valid_o && out_ready_i;
  assign pop_o                  = beat && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (beat) begin
      idx_q <= is_last ? '0 : idx_q + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ hdl/button_gesture_decoder.sv @@
// Top level of the four-button gesture decoder.
// Depends on bgd_pkg, bgd_front, bgd_fifo and bgd_back.
`default_nettype none

// Gesture decoder for buttons A..D. Input beats are either timestamped press or
// release edges or periodic ticks carrying pin levels; output beats are event codes,
// with last set on the final event an input beat causes (an item may cause none).
// Rate: the front end takes one input beat per clock whenever the event queue has
// room, and resolves all state for that beat in the same cycle. The back end hands
// out one event per clock while out_ready_i is high; an item that produces n events
// (n is at most 7) leaves as n beats, and items with none never reach the queue.
// QUEUE_DEPTH bundles of pending events decouple the two sides. Config writes take
// effect at the next clock and must only be issued while the block is idle.
// TIME_BITS sets the width of the stored timestamps; timestamps wrap at that width.
module button_gesture_decoder import bgd_pkg::*; #(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_data_o
);

  cfg_wr_t cfg;
  bundle_t bundle, head;
  logic    accept, push, pop, full, empty;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // front stalls only when no queue slot is free
  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && (bundle.cnt != '0);

  bgd_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .item_i   (in_data_i),
    .bundle_o (bundle)
  );

  bgd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (bundle),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  bgd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ hdl/bgd_checker.sv @@
// Port-level checker for the gesture decoder, bound to the top level.
// Depends on bgd_pkg and button_gesture_decoder_defines.svh.
`default_nettype none
`include "button_gesture_decoder_defines.svh"

module bgd_checker import bgd_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             cfg_we_i,
  input wire logic [1:0]       cfg_idx_i,
  input wire logic [CFG_W-1:0] cfg_data_i,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire in_item_t         in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire out_item_t        out_data_o
);

  // a stalled front means the queue holds events to send
  `BGD_ASSERT_IMPL(a_stall_has_work, clk_i, rst_ni, !in_ready_o, out_valid_o)
  // only defined event codes leave the block
  `BGD_ASSERT_IMPL(a_code_range, clk_i, rst_ni, out_valid_o, out_data_o.event_code <= EV_SYNC)
  `BGD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `BGD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))

endmodule

bind button_gesture_decoder bgd_checker u_bgd_checker (.*);

`default_nettype wire
